/* src/vgn_pkg.sv */
// ============================================================================
// vgn_pkg - shared constants and types for the voxel gradient/normal block
// Field widths, configuration register indexes and reset values.
// ============================================================================
package vgn_pkg;

    localparam int SAMPLE_BITS_DEF = 16;

    localparam int WMIN_W     = 16;
    localparam int GAIN_W     = 32;
    localparam int GAIN_FRAC  = 16;
    localparam int SCALE_W    = 24;
    localparam int BYTE_W     = 8;
    localparam int MAG_W      = 32;
    localparam int MAG_SHIFT  = 9;   // Q.17 root to Q24.8 magnitude
    localparam int WIN_SAT_B  = 24;  // window differences at or above 2^24 saturate
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_AXES   = 3;
    localparam int DIV_STAGES = BYTE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_MIN  = 3'd0,
        CFG_WINDOW_GAIN = 3'd1,
        CFG_VALUES_ONLY = 3'd2,
        CFG_SCALE_X     = 3'd3,
        CFG_SCALE_Y     = 3'd4,
        CFG_SCALE_Z     = 3'd5
    } t_cfg_idx;

    localparam logic [WMIN_W-1:0]  WMIN_RST  = 16'd0;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 32'd65536;
    localparam logic [SCALE_W-1:0] SCALE_RST = 24'd65536;

    localparam logic [BYTE_W-1:0]  BYTE_ZERO     = 8'd0;
    localparam logic [BYTE_W-1:0]  BYTE_MAX      = 8'd255;
    localparam logic [BYTE_W-1:0]  NORMAL_CENTER = 8'd127;

endpackage

/* src/vgn_isqrt.sv */
// ============================================================================
// vgn_isqrt - pipelined integer square root
// One root bit per stage, remainder carried along; sideband rides with it.
// ============================================================================
module vgn_isqrt #(
    parameter int RAD_W  = 86,
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [RAD_W-1:0]     i_rad,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [RAD_W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]    o_side
);
    localparam int ROOT_W = RAD_W / 2;

    logic              r_vld  [1:ROOT_W];
    logic [RAD_W-1:0]  r_rem  [1:ROOT_W];
    logic [ROOT_W-1:0] r_root [1:ROOT_W];
    logic [SIDE_W-1:0] r_side [1:ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        localparam int K = ROOT_W - 1 - g;
        logic              s_vld;
        logic [RAD_W-1:0]  s_rem;
        logic [RAD_W-1:0]  s_delta;
        logic [ROOT_W-1:0] s_root;
        logic [SIDE_W-1:0] s_side;
        logic [RAD_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (g == 0) begin : g_in
            assign s_vld  = i_valid;
            assign s_rem  = i_rad;
            assign s_root = '0;
            assign s_side = i_side;
        end else begin : g_mid
            assign s_vld  = r_vld[g];
            assign s_rem  = r_rem[g];
            assign s_root = r_root[g];
            assign s_side = r_side[g];
        end

        // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k); r has no bits below k+1
        assign s_delta = (RAD_W'(s_root) << (K + 1)) | (RAD_W'(1) << (2 * K));

        always_comb begin
            n_rem  = s_rem;
            n_root = s_root;
            if (s_rem >= s_delta) begin
                n_rem  = s_rem - s_delta;
                n_root = s_root | (ROOT_W'(1) << K);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g+1]  <= n_rem;
            r_root[g+1] <= n_root;
            r_side[g+1] <= s_side;
        end
    end

    assign o_valid = r_vld[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_side  = r_side[ROOT_W];

endmodule

/* src/vgn_ndiv.sv */
// ============================================================================
// vgn_ndiv - pipelined 8-bit quotient restoring divider
// One quotient bit per stage; quotient known to fit in a byte.
// ============================================================================
module vgn_ndiv #(
    parameter int NUM_W = 52,
    parameter int DEN_W = 44
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [NUM_W-1:0]           i_num,
    input  logic [DEN_W-1:0]           i_den,
    output logic                       o_valid,
    output logic [vgn_pkg::BYTE_W-1:0] o_quo
);
    import vgn_pkg::*;

    logic              r_vld [1:DIV_STAGES];
    logic [NUM_W-1:0]  r_rem [1:DIV_STAGES];
    logic [DEN_W-1:0]  r_den [1:DIV_STAGES];
    logic [BYTE_W-1:0] r_quo [1:DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        localparam int K = DIV_STAGES - 1 - g;
        logic              s_vld;
        logic [NUM_W-1:0]  s_rem;
        logic [DEN_W-1:0]  s_den;
        logic [BYTE_W-1:0] s_quo;
        logic [NUM_W-1:0]  s_dsh;
        logic [NUM_W-1:0]  n_rem;
        logic [BYTE_W-1:0] n_quo;

        if (g == 0) begin : g_in
            assign s_vld = i_valid;
            assign s_rem = i_num;
            assign s_den = i_den;
            assign s_quo = '0;
        end else begin : g_mid
            assign s_vld = r_vld[g];
            assign s_rem = r_rem[g];
            assign s_den = r_den[g];
            assign s_quo = r_quo[g];
        end

        assign s_dsh = NUM_W'(s_den) << K;

        always_comb begin
            n_rem = s_rem;
            n_quo = s_quo;
            if (s_rem >= s_dsh) begin
                n_rem = s_rem - s_dsh;
                n_quo = s_quo | (BYTE_W'(1) << K);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g+1] <= n_rem;
            r_den[g+1] <= s_den;
            r_quo[g+1] <= n_quo;
        end
    end

    assign o_valid = r_vld[DIV_STAGES];
    assign o_quo   = r_quo[DIV_STAGES];

endmodule

/* src/voxel_gradient_normal_and_window.sv */
// ============================================================================
// voxel_gradient_normal_and_window - central-difference gradient, normal, window
// Pipeline from start to o_valid: the front stages, the one-bit-per-stage square
//   root (SAMPLE_BITS + 27 stages), the normal numerator stage, the 8-stage normal
//   divider and the output register.
// Throughput: one transaction per cycle; o_busy is always low and the result
//   strobe cannot be held off, so nothing ever stalls.
// Reset (synchronous, active low): empties the pipeline and restores the
//   configuration registers to their defaults.
// ============================================================================
module voxel_gradient_normal_and_window #(
    parameter int SAMPLE_BITS = vgn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vgn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vgn_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // command side
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic signed [SAMPLE_BITS-1:0]  i_center_sample,
    input  logic signed [SAMPLE_BITS-1:0]  i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]  i_right_sample,
    input  logic signed [SAMPLE_BITS-1:0]  i_lower_sample,
    input  logic signed [SAMPLE_BITS-1:0]  i_upper_sample,
    input  logic signed [SAMPLE_BITS-1:0]  i_back_sample,
    input  logic signed [SAMPLE_BITS-1:0]  i_front_sample,
    input  logic                           i_x_edge,
    input  logic                           i_y_edge,
    input  logic                           i_z_edge,
    // result side
    output logic                           o_valid,
    output logic [vgn_pkg::BYTE_W-1:0]     o_normal_x_byte,
    output logic [vgn_pkg::BYTE_W-1:0]     o_normal_y_byte,
    output logic [vgn_pkg::BYTE_W-1:0]     o_normal_z_byte,
    output logic [vgn_pkg::BYTE_W-1:0]     o_value_byte,
    output logic [vgn_pkg::MAG_W-1:0]      o_grad_magnitude
);
    import vgn_pkg::*;

    // ---- derived widths ----------------------------------------------------
    localparam int DW   = SAMPLE_BITS + 2;        // axis difference, doubled at edges
    localparam int CW   = DW + SCALE_W;           // scaled component, Q.17
    localparam int AW   = CW;                     // magnitude of component
    localparam int LW   = AW / 2;                 // square split: low half
    localparam int HW   = AW - LW;                // square split: high half
    localparam int SQW  = 2 * AW;                 // one square
    localparam int SW   = SQW + 2;                // sum of three squares (even)
    localparam int RW   = SW / 2;                 // root width
    localparam int AXW  = RW + 1;                 // m +/- |c|
    localparam int NMW  = AXW + BYTE_W + 1;       // 255 * (m +/- |c|)
    localparam int XW   = ((SAMPLE_BITS > WMIN_W) ? SAMPLE_BITS : WMIN_W) + 1;
    localparam int EW   = XW + WIN_SAT_B + 1;
    localparam int PW   = WIN_SAT_B + GAIN_W;     // window product
    localparam int VW   = PW - GAIN_FRAC;
    localparam int SIDE_W = BYTE_W + NUM_AXES + NUM_AXES * AW;
    localparam int LAT  = RW + 16;                // register stages start to o_valid

    // ---- configuration registers -------------------------------------------
    logic signed [WMIN_W-1:0]  r_window_min;
    logic        [GAIN_W-1:0]  r_window_gain;
    logic                      r_values_only;
    logic signed [SCALE_W-1:0] r_scale [NUM_AXES];

    assign o_cfg_ready = 1'b1;

    // unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_min  <= WMIN_RST;
            r_window_gain <= GAIN_RST;
            r_values_only <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_scale[a] <= SCALE_RST;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WINDOW_MIN:  r_window_min  <= i_cfg_data[WMIN_W-1:0];
                CFG_WINDOW_GAIN: r_window_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_VALUES_ONLY: r_values_only <= i_cfg_data[0];
                CFG_SCALE_X:     r_scale[0]    <= i_cfg_data[SCALE_W-1:0];
                CFG_SCALE_Y:     r_scale[1]    <= i_cfg_data[SCALE_W-1:0];
                CFG_SCALE_Z:     r_scale[2]    <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Every stage accepts each cycle; there is no back pressure anywhere.
    assign o_busy = 1'b0;

    logic s_accept;
    assign s_accept = i_start && !o_busy;

    // ---- stage 1: axis differences, window offset --------------------------
    logic signed [SAMPLE_BITS-1:0] s_lo [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] s_hi [NUM_AXES];
    logic                          s_edge [NUM_AXES];

    assign s_lo[0] = i_left_sample;   assign s_hi[0] = i_right_sample;
    assign s_lo[1] = i_lower_sample;  assign s_hi[1] = i_upper_sample;
    assign s_lo[2] = i_back_sample;   assign s_hi[2] = i_front_sample;
    assign s_edge[0] = i_x_edge;
    assign s_edge[1] = i_y_edge;
    assign s_edge[2] = i_z_edge;

    logic                 r1_vld;
    logic signed [DW-1:0] r1_d [NUM_AXES];
    logic signed [XW-1:0] r1_wd;
    logic signed [DW-1:0] n1_d [NUM_AXES];

    // central difference is kept in half units; a one-sided edge doubles it
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n1_d[a] = DW'(s_hi[a]) - DW'(s_lo[a]);
            if (s_edge[a]) begin
                n1_d[a] = n1_d[a] <<< 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_d  <= n1_d;
        r1_wd <= XW'(i_center_sample) - XW'(r_window_min);
    end

    // ---- stage 2: scale multiply, window gain multiply ---------------------
    logic                 r2_vld;
    logic signed [CW-1:0] r2_comp [NUM_AXES];
    logic                 r2_wpos;
    logic                 r2_wbig;
    logic [PW-1:0]        r2_wprod;
    logic signed [EW-1:0] s_wd_ext;

    assign s_wd_ext = EW'(r1_wd);

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NUM_AXES; a++) begin
            r2_comp[a] <= r1_d[a] * r_scale[a];
        end
        r2_wpos  <= (r1_wd > 0);
        r2_wbig  <= (s_wd_ext >= $signed(EW'(1) << WIN_SAT_B));
        r2_wprod <= PW'(s_wd_ext[WIN_SAT_B-1:0]) * PW'(r_window_gain);
    end

    // ---- stage 3: component magnitude and sign, value byte -----------------
    logic                r3_vld;
    logic [AW-1:0]       r3_ac  [NUM_AXES];
    logic                r3_neg [NUM_AXES];
    logic [BYTE_W-1:0]   r3_vbyte;
    logic [BYTE_W-1:0]   n3_vbyte;
    logic [VW-1:0]       s_wval;

    assign s_wval = r2_wprod[PW-1:GAIN_FRAC];

    // nonpositive offset or zero gain gives 0; large offsets or windowed values above 255 clamp to 255
    always_comb begin
        if (!r2_wpos || (r_window_gain == '0)) begin
            n3_vbyte = BYTE_ZERO;
        end else if (r2_wbig || (s_wval > VW'(BYTE_MAX))) begin
            n3_vbyte = BYTE_MAX;
        end else begin
            n3_vbyte = s_wval[BYTE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NUM_AXES; a++) begin
            r3_neg[a] <= r2_comp[a][CW-1];
            r3_ac[a]  <= r2_comp[a][CW-1] ? AW'(-r2_comp[a]) : AW'(r2_comp[a]);
        end
        r3_vbyte <= n3_vbyte;
    end

    // ---- stage 4: partial products of the squares --------------------------
    logic                 r4_vld;
    logic [2*HW-1:0]      r4_hh [NUM_AXES];
    logic [HW+LW-1:0]     r4_hl [NUM_AXES];
    logic [2*LW-1:0]      r4_ll [NUM_AXES];
    logic [AW-1:0]        r4_ac  [NUM_AXES];
    logic                 r4_neg [NUM_AXES];
    logic [BYTE_W-1:0]    r4_vbyte;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NUM_AXES; a++) begin
            r4_hh[a] <= r3_ac[a][AW-1:LW] * r3_ac[a][AW-1:LW];
            r4_hl[a] <= r3_ac[a][AW-1:LW] * r3_ac[a][LW-1:0];
            r4_ll[a] <= r3_ac[a][LW-1:0]  * r3_ac[a][LW-1:0];
        end
        r4_ac    <= r3_ac;
        r4_neg   <= r3_neg;
        r4_vbyte <= r3_vbyte;
    end

    // ---- stage 5: per-axis square ------------------------------------------
    logic                 r5_vld;
    logic [SQW-1:0]       r5_sq  [NUM_AXES];
    logic [AW-1:0]        r5_ac  [NUM_AXES];
    logic                 r5_neg [NUM_AXES];
    logic [BYTE_W-1:0]    r5_vbyte;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NUM_AXES; a++) begin
            r5_sq[a] <= (SQW'(r4_hh[a]) << (2 * LW))
                      + (SQW'(r4_hl[a]) << (LW + 1))
                      + SQW'(r4_ll[a]);
        end
        r5_ac    <= r4_ac;
        r5_neg   <= r4_neg;
        r5_vbyte <= r4_vbyte;
    end

    // ---- stage 6: sum of squares -------------------------------------------
    logic                 r6_vld;
    logic [SW-1:0]        r6_sum;
    logic [AW-1:0]        r6_ac  [NUM_AXES];
    logic                 r6_neg [NUM_AXES];
    logic [BYTE_W-1:0]    r6_vbyte;

    always_ff @(posedge i_clk) begin
        r6_sum   <= SW'(r5_sq[0]) + SW'(r5_sq[1]) + SW'(r5_sq[2]);
        r6_ac    <= r5_ac;
        r6_neg   <= r5_neg;
        r6_vbyte <= r5_vbyte;
    end

    // valid bits for the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            r1_vld <= s_accept;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    // ---- square root: gradient length in Q.17 ------------------------------
    logic              s_sq_vld;
    logic [RW-1:0]     s_sq_root;
    logic [SIDE_W-1:0] s_sq_side;

    vgn_isqrt #(
        .RAD_W  (SW),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_vld),
        .i_rad   (r6_sum),
        .i_side  ({r6_vbyte, r6_neg[2], r6_neg[1], r6_neg[0],
                   r6_ac[2], r6_ac[1], r6_ac[0]}),
        .o_valid (s_sq_vld),
        .o_root  (s_sq_root),
        .o_side  (s_sq_side)
    );

    logic [AW-1:0]     s_sq_ac  [NUM_AXES];
    logic              s_sq_neg [NUM_AXES];
    logic [BYTE_W-1:0] s_sq_vbyte;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            s_sq_ac[a]  = s_sq_side[a*AW +: AW];
            s_sq_neg[a] = s_sq_side[NUM_AXES*AW + a];
        end
        s_sq_vbyte = s_sq_side[SIDE_W-1 -: BYTE_W];
    end

    // ---- stage 7: normal numerators, magnitude -----------------------------
    logic                r7_vld;
    logic [NMW-1:0]      r7_num [NUM_AXES];
    logic [AXW-1:0]      r7_den;
    logic                r7_zero;
    logic [MAG_W-1:0]    r7_mag;
    logic [BYTE_W-1:0]   r7_vbyte;

    logic [AXW-1:0]      n7_a [NUM_AXES];
    logic [RW+MAG_W-1:0] s_mext;
    logic [MAG_W-1:0]    n7_mag;

    // |c| clamps to m so that 0 <= m +/- |c| <= 2m and the quotient fits a byte
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            logic [RW-1:0] acc;
            acc = (RW'(s_sq_ac[a]) > s_sq_root) ? s_sq_root : RW'(s_sq_ac[a]);
            n7_a[a] = s_sq_neg[a] ? (AXW'(s_sq_root) - AXW'(acc))
                                  : (AXW'(s_sq_root) + AXW'(acc));
        end
    end

    // Q.17 root to Q24.8, saturating
    always_comb begin
        s_mext = (RW + MAG_W)'(s_sq_root) >> MAG_SHIFT;
        if (|s_mext[RW+MAG_W-1:MAG_W]) begin
            n7_mag = '1;
        end else begin
            n7_mag = s_mext[MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= s_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NUM_AXES; a++) begin
            r7_num[a] <= (NMW'(n7_a[a]) << BYTE_W) - NMW'(n7_a[a]);
        end
        r7_den   <= {s_sq_root, 1'b0};
        r7_zero  <= (s_sq_root == '0);
        r7_mag   <= n7_mag;
        r7_vbyte <= s_sq_vbyte;
    end

    // ---- normal bytes: floor(255 * (m +/- |c|) / 2m) -----------------------
    logic              s_dv_vld [NUM_AXES];
    logic [BYTE_W-1:0] s_dv_quo [NUM_AXES];

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        vgn_ndiv #(
            .NUM_W (NMW),
            .DEN_W (AXW)
        ) u_ndiv (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r7_vld),
            .i_num   (r7_num[g]),
            .i_den   (r7_den),
            .o_valid (s_dv_vld[g]),
            .o_quo   (s_dv_quo[g])
        );
    end

    // sideband delay matching the divider
    logic              r8_zero  [1:DIV_STAGES];
    logic [MAG_W-1:0]  r8_mag   [1:DIV_STAGES];
    logic [BYTE_W-1:0] r8_vbyte [1:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        r8_zero[1]  <= r7_zero;
        r8_mag[1]   <= r7_mag;
        r8_vbyte[1] <= r7_vbyte;
        for (int i = 2; i <= DIV_STAGES; i++) begin
            r8_zero[i]  <= r8_zero[i-1];
            r8_mag[i]   <= r8_mag[i-1];
            r8_vbyte[i] <= r8_vbyte[i-1];
        end
    end

    // ---- output register ---------------------------------------------------
    logic              r_out_vld;
    logic [BYTE_W-1:0] r_out_n [NUM_AXES];
    logic [BYTE_W-1:0] r_out_vbyte;
    logic [MAG_W-1:0]  r_out_mag;
    logic [BYTE_W-1:0] n_out_n [NUM_AXES];

    // values-only forces normals to 0; a zero-length gradient gives 127
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (r_values_only) begin
                n_out_n[a] = BYTE_ZERO;
            end else if (r8_zero[DIV_STAGES]) begin
                n_out_n[a] = NORMAL_CENTER;
            end else begin
                n_out_n[a] = s_dv_quo[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= s_dv_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_n     <= n_out_n;
        r_out_vbyte <= r8_vbyte[DIV_STAGES];
        r_out_mag   <= r8_mag[DIV_STAGES];
    end

    assign o_valid          = r_out_vld;
    assign o_normal_x_byte  = r_out_n[0];
    assign o_normal_y_byte  = r_out_n[1];
    assign o_normal_z_byte  = r_out_n[2];
    assign o_value_byte     = r_out_vbyte;
    assign o_grad_magnitude = r_out_mag;

    // ---- assertions ----------------------------------------------------------
    // every result strobe traces back to a start that has passed through all LAT register stages
    a_lat_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LAT))
        else $error("result strobe without matching start");

    // reset empties the pipeline
    a_rst_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // zero gain always windows to byte 0
    a_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_window_gain == '0)) |-> (o_value_byte == BYTE_ZERO))
        else $error("nonzero value byte with zero gain");

    // values-only mode forces all normal bytes to 0
    a_values_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_values_only) |->
            (o_normal_x_byte == BYTE_ZERO && o_normal_y_byte == BYTE_ZERO &&
             o_normal_z_byte == BYTE_ZERO))
        else $error("normal bytes not cleared in values-only mode");

endmodule

/* dv/testbench.sv */
// ============================================================================
// testbench - self-checking bench for voxel_gradient_normal_and_window
// Streams voxel transactions through the command port and reprograms the
// window, gain, values-only and axis scales between phases. A scoreboard
// predicts the gradient magnitude, normal bytes and value byte of every
// accepted transaction and checks them in order against the result strobe.
// ============================================================================
module testbench;
    import vgn_pkg::*;

    localparam int SB       = SAMPLE_BITS_DEF;
    localparam int DRAIN    = 80;       // beyond the pipeline depth
    localparam int MAX_CYC  = 600000;
    localparam int N_PHASES = 6;
    localparam int PHASE_N  = 325;

    // indexes past the register file; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic signed [SB-1:0] center;
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
        logic signed [SB-1:0] lower;
        logic signed [SB-1:0] upper;
        logic signed [SB-1:0] back;
        logic signed [SB-1:0] front;
        logic                 x_edge;
        logic                 y_edge;
        logic                 z_edge;
    } voxel_t;

    typedef struct packed {
        logic [BYTE_W-1:0] nx;
        logic [BYTE_W-1:0] ny;
        logic [BYTE_W-1:0] nz;
        logic [BYTE_W-1:0] value;
        logic [MAG_W-1:0]  mag;
    } shade_t;

    // ------------------------------------------------------------------
    // Scoreboard: shadow registers plus in-order queue of predicted shades
    // ------------------------------------------------------------------
    class shade_scoreboard;
        logic signed [WMIN_W-1:0]  wmin;
        logic [GAIN_W-1:0]         gain;
        logic                      vals_only;
        logic signed [SCALE_W-1:0] scale [NUM_AXES];
        shade_t                    pending_q [$];
        int                        errors;

        function new();
            wmin      = WMIN_RST;
            gain      = GAIN_RST;
            vals_only = 1'b0;
            foreach (scale[a]) scale[a] = SCALE_RST;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WINDOW_MIN:  wmin      = data[WMIN_W-1:0];
                CFG_WINDOW_GAIN: gain      = data;
                CFG_VALUES_ONLY: vals_only = data[0];
                CFG_SCALE_X:     scale[0]  = data[SCALE_W-1:0];
                CFG_SCALE_Y:     scale[1]  = data[SCALE_W-1:0];
                CFG_SCALE_Z:     scale[2]  = data[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        // gradient -> normal bytes, magnitude and windowed value
        function shade_t shade_of(voxel_t v);
            longint       minus [NUM_AXES];
            longint       plus  [NUM_AXES];
            longint       comp  [NUM_AXES];
            logic [127:0] mag2, acomp, tt, num;
            logic [63:0]  root, t, ac, a;
            longint       diff;
            logic [63:0]  wv;
            logic [BYTE_W-1:0] nb [NUM_AXES];
            shade_t       s;
            minus[0] = v.left;  plus[0] = v.right;
            minus[1] = v.lower; plus[1] = v.upper;
            minus[2] = v.back;  plus[2] = v.front;
            mag2 = '0;
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                diff = plus[ax] - minus[ax];
                // one-sided difference at a boundary counts double in half units
                if ((ax == 0 && v.x_edge) || (ax == 1 && v.y_edge) || (ax == 2 && v.z_edge))
                    diff = diff * 2;
                comp[ax] = diff * longint'(scale[ax]);
                acomp = (comp[ax] < 0) ? 128'(-comp[ax]) : 128'(comp[ax]);
                mag2 += acomp * acomp;
            end
            root = '0;
            for (int b = 59; b >= 0; b--) begin
                t  = root | (64'd1 << b);
                tt = 128'(t);
                if (tt * tt <= mag2) root = t;
            end
            s.mag = ((root >> MAG_SHIFT) > 64'hFFFF_FFFF) ? '1 : MAG_W'(root >> MAG_SHIFT);
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                if (root == 0) begin
                    nb[ax] = NORMAL_CENTER;
                end else begin
                    ac = (comp[ax] < 0) ? 64'(-comp[ax]) : 64'(comp[ax]);
                    if (ac > root) ac = root;
                    a   = (comp[ax] < 0) ? root - ac : root + ac;
                    num = (128'(a) * 128'd255) / (128'(root) * 128'd2);
                    nb[ax] = num[BYTE_W-1:0];
                end
                if (vals_only) nb[ax] = BYTE_ZERO;
            end
            s.nx = nb[0]; s.ny = nb[1]; s.nz = nb[2];
            diff = longint'(v.center) - longint'(wmin);
            if (diff <= 0 || gain == 0) begin
                s.value = BYTE_ZERO;
            end else if (diff >= (longint'(1) << WIN_SAT_B)) begin
                s.value = BYTE_MAX;
            end else begin
                wv = (64'(diff) * 64'(gain)) >> GAIN_FRAC;
                s.value = (wv > 255) ? BYTE_MAX : wv[BYTE_W-1:0];
            end
            return s;
        endfunction

        function void note_voxel(voxel_t v);
            pending_q.push_back(shade_of(v));
        endfunction

        function void check_shade(shade_t got);
            shade_t want;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result nx=%0d ny=%0d nz=%0d val=%0d mag=%0h",
                         $time, got.nx, got.ny, got.nz, got.value, got.mag);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.nx !== want.nx) begin
                $display("%0t: normal_x exp %0d got %0d", $time, want.nx, got.nx);
                errors++;
            end
            if (got.ny !== want.ny) begin
                $display("%0t: normal_y exp %0d got %0d", $time, want.ny, got.ny);
                errors++;
            end
            if (got.nz !== want.nz) begin
                $display("%0t: normal_z exp %0d got %0d", $time, want.nz, got.nz);
                errors++;
            end
            if (got.value !== want.value) begin
                $display("%0t: value exp %0d got %0d", $time, want.value, got.value);
                errors++;
            end
            if (got.mag !== want.mag) begin
                $display("%0t: magnitude exp %0h got %0h", $time, want.mag, got.mag);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_start     = 1'b0;
    logic                  o_busy;
    voxel_t                vox = '0;
    logic                  o_valid;
    shade_t                res;

    voxel_gradient_normal_and_window #(.SAMPLE_BITS(SB)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_center_sample (vox.center),
        .i_left_sample   (vox.left),
        .i_right_sample  (vox.right),
        .i_lower_sample  (vox.lower),
        .i_upper_sample  (vox.upper),
        .i_back_sample   (vox.back),
        .i_front_sample  (vox.front),
        .i_x_edge        (vox.x_edge),
        .i_y_edge        (vox.y_edge),
        .i_z_edge        (vox.z_edge),
        .o_valid         (o_valid),
        .o_normal_x_byte (res.nx),
        .o_normal_y_byte (res.ny),
        .o_normal_z_byte (res.nz),
        .o_value_byte    (res.value),
        .o_grad_magnitude(res.mag)
    );

    shade_scoreboard sb = new();
    int cycles = 0;

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge. Inputs are stable
    // here since they only move on the falling edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("voxel_gradient_normal_and_window: mismatch");
            $finish;
        end
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_start && !o_busy)         sb.note_voxel(vox);
            if (o_valid)                    sb.check_shade(res);
        end
    end

    // ------------------------------------------------------------------
    // Drivers. o_busy/o_cfg_ready only move at the rising edge, so the value
    // seen at the falling edge holds for the next rising edge.
    // ------------------------------------------------------------------
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        while (!o_cfg_ready) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // leaves start high; the next transaction or an idle cycle replaces it
    task automatic send_voxel(voxel_t v);
        @(negedge i_clk);
        vox     = v;
        i_start = 1'b1;
        while (o_busy) @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_start = 1'b0;
        end
    endtask

    // wait out the pipeline before touching the registers
    task automatic drain();
        idle_cycles(1);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic program_regs(logic signed [WMIN_W-1:0] wmin, logic [GAIN_W-1:0] gain,
                                logic vonly, logic signed [SCALE_W-1:0] sx,
                                logic signed [SCALE_W-1:0] sy,
                                logic signed [SCALE_W-1:0] sz);
        cfg_write(CFG_WINDOW_MIN, CFG_DATA_W'(wmin));
        cfg_write(CFG_WINDOW_GAIN, gain);
        cfg_write(CFG_VALUES_ONLY, CFG_DATA_W'(vonly));
        cfg_write(CFG_SCALE_X, CFG_DATA_W'(sx));
        cfg_write(CFG_SCALE_Y, CFG_DATA_W'(sy));
        cfg_write(CFG_SCALE_Z, CFG_DATA_W'(sz));
    endtask

    function automatic voxel_t flat_voxel(logic signed [SB-1:0] c);
        voxel_t v;
        v = '{c, c, c, c, c, c, c, 1'b0, 1'b0, 1'b0};
        return v;
    endfunction

    function automatic logic signed [SB-1:0] rnd_sample();
        return SB'($urandom);
    endfunction

    // Mostly a smooth neighborhood around the center, with boundary voxels
    // repeating the center on one side; the rest is unconstrained noise.
    function automatic voxel_t rnd_voxel();
        voxel_t v;
        int     spread;
        if ($urandom_range(0, 3) == 0) begin
            v = '{rnd_sample(), rnd_sample(), rnd_sample(), rnd_sample(), rnd_sample(),
                  rnd_sample(), rnd_sample(), 1'($urandom), 1'($urandom), 1'($urandom)};
            return v;
        end
        spread   = 1 << $urandom_range(0, 12);
        v.center = rnd_sample();
        v.left   = SB'(int'(v.center) + $urandom_range(0, 2 * spread) - spread);
        v.right  = SB'(int'(v.center) + $urandom_range(0, 2 * spread) - spread);
        v.lower  = SB'(int'(v.center) + $urandom_range(0, 2 * spread) - spread);
        v.upper  = SB'(int'(v.center) + $urandom_range(0, 2 * spread) - spread);
        v.back   = SB'(int'(v.center) + $urandom_range(0, 2 * spread) - spread);
        v.front  = SB'(int'(v.center) + $urandom_range(0, 2 * spread) - spread);
        v.x_edge = ($urandom_range(0, 3) == 0);
        v.y_edge = ($urandom_range(0, 3) == 0);
        v.z_edge = ($urandom_range(0, 3) == 0);
        if (v.x_edge) begin
            if ($urandom_range(0, 1)) v.left = v.center; else v.right = v.center;
        end
        if (v.y_edge) begin
            if ($urandom_range(0, 1)) v.lower = v.center; else v.upper = v.center;
        end
        if (v.z_edge) begin
            if ($urandom_range(0, 1)) v.back = v.center; else v.front = v.center;
        end
        return v;
    endfunction

    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        voxel_t v;
        int     gap_pct;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset configuration
        send_voxel(flat_voxel('0));                         // zero gradient
        send_voxel(flat_voxel(SMAX));
        send_voxel(flat_voxel(SMIN));
        send_voxel('{SB'(100), SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, 1'b0, 1'b0, 1'b0});
        send_voxel('{SB'(-5), SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, 1'b1, 1'b1, 1'b1});
        send_voxel('{SB'(300), SB'(0), SB'(10), SB'(0), SB'(0), SB'(0), SB'(0),
                     1'b0, 1'b0, 1'b0});                    // pure x gradient
        send_voxel('{SB'(7), SB'(7), SB'(9), SB'(3), SB'(7), SB'(7), SB'(1),
                     1'b1, 1'b0, 1'b1});                    // boundary voxel
        send_voxel('{SB'(1), SB'(0), SB'(1), SB'(0), SB'(0), SB'(0), SB'(0),
                     1'b0, 1'b0, 1'b0});                    // half-step gradient
        drain();

        // tiny gradient: sub-LSB magnitude, normals still defined
        program_regs(SMIN, 32'd0, 1'b0, 24'sd1, -24'sd1, 24'sd0);
        send_voxel('{SB'(1), SB'(0), SB'(1), SB'(0), SB'(0), SB'(0), SB'(0),
                     1'b0, 1'b0, 1'b0});
        send_voxel('{SMAX, SB'(0), SB'(1), SB'(1), SB'(0), SB'(2), SB'(5),
                     1'b1, 1'b1, 1'b0});
        drain();
        cfg_write(CFG_SPARE_A, '1);
        cfg_write(CFG_SPARE_B, 32'h1234_5678);
        send_voxel('{SB'(1), SB'(0), SB'(1), SB'(0), SB'(0), SB'(0), SB'(0),
                     1'b0, 1'b0, 1'b0});
        drain();

        // extreme scales, huge gain, with values only on and then off
        program_regs(SMAX, 32'hFFFF_FFFF, 1'b1, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
        send_voxel('{SMAX, SMIN, SMAX, SMAX, SMIN, SMIN, SMAX, 1'b1, 1'b1, 1'b1});
        send_voxel('{SMIN, SMAX, SMIN, SMIN, SMAX, SMAX, SMIN, 1'b0, 1'b0, 1'b0});
        send_voxel(flat_voxel(SMAX));
        drain();
        program_regs(SMIN, 32'hFFFF_FFFF, 1'b0, 24'sh800000, 24'sh800000, 24'sh800000);
        send_voxel('{SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, 1'b1, 1'b1, 1'b1});
        send_voxel('{SB'(-32767), SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, 1'b1, 1'b1, 1'b1});
        drain();

        // random phases with varied configuration and sender idling
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: program_regs('0, 32'd65536, 1'b0, 24'sd65536, 24'sd65536, 24'sd65536);
                5: program_regs(SMAX, 32'hFFFF_FFFF, 1'b1, 24'sh800000, 24'sh7FFFFF, 24'sd1);
                default: program_regs(WMIN_W'($urandom), ($urandom_range(0, 1) ? $urandom
                                      : $urandom_range(0, 1 << 20)), 1'($urandom),
                                      SCALE_W'($urandom), SCALE_W'($urandom_range(0, 1 << 18)),
                                      SCALE_W'(-$urandom_range(0, 1 << 18)));
            endcase
            case (ph % 3)
                0: gap_pct = 0;
                1: gap_pct = 54;
                default: gap_pct = 17;
            endcase
            for (int n = 0; n < PHASE_N; n++) begin
                v = rnd_voxel();
                send_voxel(v);
                // geometric idle run: gap_pct percent of cycles end up idle
                while ($urandom_range(0, 99) < gap_pct) idle_cycles(1);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("voxel_gradient_normal_and_window: match");
        end else begin
            $display("voxel_gradient_normal_and_window: mismatch");
        end
        $finish;
    end

endmodule

/* voxel_gradient_normal_and_window.f */
src/vgn_pkg.sv
src/vgn_isqrt.sv
src/vgn_ndiv.sv
src/voxel_gradient_normal_and_window.sv
dv/testbench.sv
